// ===== hdl/pps_pkg.sv =====
// Shared constants and types for the preemptive priority scheduler.
package pps_pkg;

	localparam int JOBS   = 16;
	localparam int TIME_W = 32;
	localparam int ID_W   = 16;
	localparam int PRIO_W = 8;
	localparam int IDX_W  = $clog2(JOBS);

	// One job table entry.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] remaining;
	} pps_entry_t;

	// Write request into the job table; a write also marks the slot valid.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		pps_entry_t       data;
	} pps_wr_t;

	// Removal of a slot from the job table.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} pps_clr_t;

endpackage

// ===== hdl/preemptive_priority_scheduler_unit.sv =====
// Top level of the preemptive priority scheduler: event sequencer and result register.
//
// The scheduler keeps up to JOBS jobs in a table memory with a registered
// read; only the per-slot valid flags live in flip-flops, so the entry
// memory needs no clearing pass after reset. An arrival item passes the
// execute state, and also the charge state when it preempts the running
// job, before the result state loads its result; on a preemption the
// running job's entry is read, charged for the time it ran and written
// back. A done item walks the whole table through the single read port,
// one slot per cycle, to pick the next job, then passes the last-compare
// and pick states before the result state loads its result. One item is
// in work at a time; in_stall is low only when the sequencer is idle, which
// it is again from the edge that loads the result. The result sits in an
// output register, so a new item is taken while an earlier result still
// waits on out_stall. Every item gives exactly one result item.
module preemptive_priority_scheduler_unit import pps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [TIME_W-1:0] now_time,
	input  logic [ID_W-1:0]   job_id,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [TIME_W-1:0] job_size,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              dispatch,
	output logic [ID_W-1:0]   run_job_id,
	output logic [TIME_W-1:0] finish_time,
	output logic              preempted,
	output logic              status,
	output logic              busy_now
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHARGE,
		ST_SCAN,
		ST_LAST,
		ST_PICK,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic              dispatch;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] finish;
		logic              preempted;
		logic              status;
		logic              busy;
	} res_t;

	// Adds two times and clamps at the largest representable tick.
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
	                                              input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	state_t            state_q;

	// The accepted item.
	logic              mode_q;
	logic [TIME_W-1:0] now_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;
	logic [TIME_W-1:0] size_q;

	// Running job bookkeeping; its priority is mirrored here so that an
	// arrival can decide on preemption without a table read.
	logic              run_q;
	logic [IDX_W-1:0]  run_slot_q;
	logic [PRIO_W-1:0] run_prio_q;
	logic [TIME_W-1:0] start_q;
	logic [IDX_W-1:0]  new_slot_q;

	// Table scan for the pick after a done item.
	logic [IDX_W-1:0]  scan_idx_q;
	logic              rd_v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              have_best_q;
	logic [IDX_W-1:0]  best_idx_q;
	pps_entry_t        best_q;

	res_t              res_q;
	res_t              out_q;
	logic              out_valid_q;

	pps_wr_t           wr;
	pps_clr_t          clr;
	logic [IDX_W-1:0]  rd_addr;
	pps_entry_t        rd_data;
	logic [JOBS-1:0]   slot_valid;

	logic              free_found;
	logic [IDX_W-1:0]  free_idx;
	logic              take;
	logic              out_free;
	logic [TIME_W-1:0] ran;
	logic [TIME_W-1:0] charged;

	pps_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.clr        (clr),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.slot_valid (slot_valid)
	);

	// Lowest free slot.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = JOBS - 1; k >= 0; k--) begin
			if (!slot_valid[k]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(k);
			end
		end
	end

	// A scanned slot replaces the best so far only when strictly better, so
	// on a full tie the lowest slot index stays.
	always_comb begin
		take = 1'b0;
		if (rd_v_s1 && slot_valid[idx_s1]) begin
			if (!have_best_q) begin
				take = 1'b1;
			end else if (rd_data.prio != best_q.prio) begin
				take = rd_data.prio > best_q.prio;
			end else if (rd_data.arrival != best_q.arrival) begin
				take = rd_data.arrival < best_q.arrival;
			end else begin
				take = rd_data.remaining < best_q.remaining;
			end
		end
	end

	// Charge for the preempted job; time running backward charges nothing.
	always_comb begin
		ran     = (now_q >= start_q) ? now_q - start_q : '0;
		charged = (rd_data.remaining > ran) ? rd_data.remaining - ran : '0;
	end

	// Table port control. The read in the execute cycle fetches the running
	// job's entry for a possible charge; writes of one item fall in separate
	// cycles and never touch the slot being read, so no forwarding is needed.
	always_comb begin
		wr                = '0;
		clr               = '0;
		rd_addr           = (state_q == ST_EXEC) ? run_slot_q : scan_idx_q;
		if (state_q == ST_EXEC) begin
			if (!mode_q && free_found) begin
				wr.en             = 1'b1;
				wr.addr           = free_idx;
				wr.data.id        = id_q;
				wr.data.prio      = prio_q;
				wr.data.arrival   = now_q;
				wr.data.remaining = size_q;
			end
			if (mode_q && run_q) begin
				clr.en   = 1'b1;
				clr.addr = run_slot_q;
			end
		end else if (state_q == ST_CHARGE) begin
			wr.en                = 1'b1;
			wr.addr              = run_slot_q;
			wr.data              = rd_data;
			wr.data.remaining    = charged;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= 1'b0;
			run_slot_q  <= '0;
			start_q     <= '0;
			rd_v_s1     <= 1'b0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				have_best_q <= 1'b1;
				best_idx_q  <= idx_s1;
				best_q      <= rd_data;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode;
						now_q   <= now_time;
						id_q    <= job_id;
						prio_q  <= priority_req;
						size_q  <= job_size;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_q <= '0;
					if (mode_q) begin
						// Done: the running job leaves and the whole table is scanned.
						run_q       <= 1'b0;
						scan_idx_q  <= '0;
						have_best_q <= 1'b0;
						state_q     <= ST_SCAN;
					end else if (!free_found) begin
						res_q.status <= 1'b1;
						res_q.busy   <= run_q;
						state_q      <= ST_PUSH;
					end else if (!run_q) begin
						run_q           <= 1'b1;
						run_slot_q      <= free_idx;
						run_prio_q      <= prio_q;
						start_q         <= now_q;
						res_q.dispatch  <= 1'b1;
						res_q.id        <= id_q;
						res_q.finish    <= sat_add(now_q, size_q);
						res_q.busy      <= 1'b1;
						state_q         <= ST_PUSH;
					end else if (prio_q > run_prio_q) begin
						new_slot_q <= free_idx;
						state_q    <= ST_CHARGE;
					end else begin
						res_q.busy <= 1'b1;
						state_q    <= ST_PUSH;
					end
				end
				ST_CHARGE: begin
					// The charged entry is written back by the port logic.
					run_slot_q      <= new_slot_q;
					run_prio_q      <= prio_q;
					start_q         <= now_q;
					res_q.dispatch  <= 1'b1;
					res_q.id        <= id_q;
					res_q.finish    <= sat_add(now_q, size_q);
					res_q.preempted <= 1'b1;
					res_q.busy      <= 1'b1;
					state_q         <= ST_PUSH;
				end
				ST_SCAN: begin
					rd_v_s1    <= 1'b1;
					idx_s1     <= scan_idx_q;
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q == IDX_W'(JOBS - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// The last slot's compare lands at this edge.
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (have_best_q) begin
						run_q          <= 1'b1;
						run_slot_q     <= best_idx_q;
						run_prio_q     <= best_q.prio;
						start_q        <= now_q;
						res_q.dispatch <= 1'b1;
						res_q.id       <= best_q.id;
						res_q.finish   <= sat_add(now_q, best_q.remaining);
						res_q.busy     <= 1'b1;
					end
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign dispatch    = out_q.dispatch;
	assign run_job_id  = out_q.id;
	assign finish_time = out_q.finish;
	assign preempted   = out_q.preempted;
	assign status      = out_q.status;
	assign busy_now    = out_q.busy;

	// The running job always occupies a valid table slot.
	a_run_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> slot_valid[run_slot_q])
		else $error("running job has no valid table slot");

	// A new result only appears after the result stage.
	a_out_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_PUSH))
		else $error("result loaded outside the result stage");

	// A preemption is always reported together with a dispatch.
	a_preempt_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.preempted |-> out_q.dispatch && out_q.busy)
		else $error("preemption reported without a dispatch");

	// Scan read data is only in flight while the scan is running.
	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == ST_SCAN || state_q == ST_LAST))
		else $error("scan read outside the scan window");

endmodule

// ===== hdl/pps_table.sv =====
// Job table: entry memory with registered read and per-slot valid flags.
module pps_table import pps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  pps_wr_t          wr,
	input  pps_clr_t         clr,
	input  logic [IDX_W-1:0] rd_addr,
	output pps_entry_t       rd_data,
	output logic [JOBS-1:0]  slot_valid
);

	pps_entry_t      mem [JOBS];
	logic [JOBS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (clr.en) begin
				valid_q[clr.addr] <= 1'b0;
			end
		end
	end

	assign slot_valid = valid_q;

endmodule
